/* rtl/ipx_pkg.sv */
// Shared types and constants of the IPv4/TCP payload extraction block.
package ipx_pkg;

   // Link-layer header length in front of the IPv4 header.
   localparam logic [15:0] LINK_HEADER_BYTES = 16'd14;
   localparam logic [7:0]  IP_PROTO_TCP      = 8'd6;
   localparam logic [3:0]  MIN_HEADER_WORDS  = 4'd5;

   // Server address register reset values, in wire order.
   localparam logic [7:0] SERVER_IP_RESET0 = 8'd192;
   localparam logic [7:0] SERVER_IP_RESET1 = 8'd243;
   localparam logic [7:0] SERVER_IP_RESET2 = 8'd0;
   localparam logic [7:0] SERVER_IP_RESET3 = 8'd0;

   // Register indexes of the configuration port.
   localparam logic [7:0] CSR_SERVER_IP0 = 8'd0;
   localparam logic [7:0] CSR_SERVER_IP1 = 8'd1;
   localparam logic [7:0] CSR_SERVER_IP2 = 8'd2;
   localparam logic [7:0] CSR_SERVER_IP3 = 8'd3;

   // Result queue; the depth must be a power of two so that the pointers wrap.
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RSP_PTR_BITS    = $clog2(RSP_QUEUE_DEPTH);

   localparam logic RESULT_PAYLOAD = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   typedef logic [3:0][7:0] ipx_ip_type;

   typedef struct packed {
      logic               kind;
      logic               last;
      logic [7:0]         payload_byte;
      logic               toward_server;
      logic               from_server;
      logic               is_tcp;
      logic               malformed;
      logic signed [16:0] payload_length;
      logic [31:0]        client_next_seq;
      logic [31:0]        server_next_seq;
   } ipx_result_type;

   // Up to two results per request; when both are present, first is the payload byte.
   typedef struct packed {
      logic           first_valid;
      logic           second_valid;
      ipx_result_type first;
      ipx_result_type second;
   } ipx_push_type;

endpackage

/* rtl/ipx_parser.sv */
// Frame header parser, payload filter and per-direction sequence tracking.
module ipx_parser
   import ipx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  logic [7:0]   frame_byte,
   input  logic         frame_end,
   input  logic [15:0]  wire_length,
   input  ipx_ip_type   server_ip,
   output ipx_push_type push
);

   logic [15:0] pos_ff, pos_in;
   logic [3:0]  ihw_ff, ihw_in;
   logic [3:0]  thw_ff, thw_in;
   logic        tcp_ff, tcp_in;
   logic        dst_ff, dst_in;
   logic        src_ff, src_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] client_ff, client_in;
   logic [31:0] server_ff, server_in;

   logic [15:0] tcp_start;
   logic [15:0] hdr_end;
   logic [15:0] addr_off;
   logic [1:0]  k;
   logic        ip_ok;
   logic        payload_ok;
   logic [16:0] captured;
   logic signed [16:0] plen;
   logic        bad;
   logic [31:0] next_seq;
   logic [31:0] client_upd, server_upd;
   ipx_result_type pay_res, sum_res;

   always_comb begin
      tcp_start = LINK_HEADER_BYTES + {10'd0, ihw_ff, 2'b00};
      ip_ok     = ihw_ff >= MIN_HEADER_WORDS;
      addr_off  = pos_ff - LINK_HEADER_BYTES - 16'd12;
      k         = addr_off[1:0];

      ihw_in = ihw_ff;
      thw_in = thw_ff;
      tcp_in = tcp_ff;
      dst_in = dst_ff;
      src_in = src_ff;
      seq_in = seq_ff;

      if (pos_ff == LINK_HEADER_BYTES) begin
         ihw_in = frame_byte[3:0];
      end else if (pos_ff == LINK_HEADER_BYTES + 16'd9) begin
         tcp_in = (frame_byte == IP_PROTO_TCP);
      end else if (pos_ff >= LINK_HEADER_BYTES + 16'd12 &&
                   pos_ff <  LINK_HEADER_BYTES + 16'd16) begin
         if (server_ip[k] != 8'd0 && server_ip[k] != frame_byte) begin
            src_in = 1'b0;
         end
      end else if (pos_ff >= LINK_HEADER_BYTES + 16'd16 &&
                   pos_ff <  LINK_HEADER_BYTES + 16'd20) begin
         if (server_ip[k] != 8'd0 && server_ip[k] != frame_byte) begin
            dst_in = 1'b0;
         end
      end else if (ip_ok && pos_ff >= tcp_start + 16'd4 && pos_ff < tcp_start + 16'd8) begin
         seq_in = {seq_ff[23:0], frame_byte};
      end else if (ip_ok && pos_ff == tcp_start + 16'd12) begin
         thw_in = frame_byte[7:4];
      end

      hdr_end = tcp_start + {10'd0, thw_in, 2'b00};

      payload_ok = ip_ok && tcp_in && (thw_in >= MIN_HEADER_WORDS) && (dst_in || src_in) &&
                   (pos_ff >= hdr_end) && (pos_ff < wire_length) && (pos_ff != 16'hFFFF);

      // End-of-frame checks use the header fields as they stand after this byte.
      captured = {1'b0, pos_ff} + 17'd1;
      plen     = tcp_in ? $signed({1'b0, wire_length} - {1'b0, hdr_end}) : 17'sd0;
      bad      = !ip_ok || (captured < {1'b0, LINK_HEADER_BYTES + 16'd20});
      if (tcp_in && (thw_in < MIN_HEADER_WORDS || plen[16] || captured < {1'b0, hdr_end})) begin
         bad = 1'b1;
      end
      next_seq   = seq_in + {15'd0, plen[16:0]};
      client_upd = (tcp_in && !bad && dst_in) ? next_seq : client_ff;
      server_upd = (tcp_in && !bad && src_in) ? next_seq : server_ff;

      pay_res                 = '0;
      pay_res.kind            = RESULT_PAYLOAD;
      pay_res.payload_byte    = frame_byte;
      pay_res.toward_server   = dst_in;
      pay_res.from_server     = src_in;
      pay_res.is_tcp          = 1'b1;

      sum_res                 = '0;
      sum_res.kind            = RESULT_SUMMARY;
      sum_res.last            = 1'b1;
      sum_res.toward_server   = dst_in;
      sum_res.from_server     = src_in;
      sum_res.is_tcp          = tcp_in;
      sum_res.malformed       = bad;
      sum_res.payload_length  = plen;
      sum_res.client_next_seq = client_upd;
      sum_res.server_next_seq = server_upd;

      push.first_valid  = fire && (payload_ok || frame_end);
      push.second_valid = fire && payload_ok && frame_end;
      push.first        = payload_ok ? pay_res : sum_res;
      push.second       = sum_res;

      client_in = client_ff;
      server_in = server_ff;
      pos_in    = pos_ff;
      if (fire) begin
         if (frame_end) begin
            client_in = client_upd;
            server_in = server_upd;
            pos_in    = 16'd0;
            ihw_in    = 4'd0;
            thw_in    = 4'd0;
            tcp_in    = 1'b0;
            dst_in    = 1'b1;
            src_in    = 1'b1;
            seq_in    = 32'd0;
         end else if (pos_ff != 16'hFFFF) begin
            pos_in = pos_ff + 16'd1;
         end
      end else begin
         ihw_in = ihw_ff;
         thw_in = thw_ff;
         tcp_in = tcp_ff;
         dst_in = dst_ff;
         src_in = src_ff;
         seq_in = seq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 16'd0;
         ihw_ff    <= 4'd0;
         thw_ff    <= 4'd0;
         tcp_ff    <= 1'b0;
         dst_ff    <= 1'b1;
         src_ff    <= 1'b1;
         seq_ff    <= 32'd0;
         client_ff <= 32'd0;
         server_ff <= 32'd0;
      end else begin
         pos_ff    <= pos_in;
         ihw_ff    <= ihw_in;
         thw_ff    <= thw_in;
         tcp_ff    <= tcp_in;
         dst_ff    <= dst_in;
         src_ff    <= src_in;
         seq_ff    <= seq_in;
         client_ff <= client_in;
         server_ff <= server_in;
      end
   end

endmodule

/* rtl/ipx_rsp_queue.sv */
// Small result queue that takes up to two results a cycle and hands out one.
module ipx_rsp_queue
   import ipx_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  ipx_push_type   push,
   input  logic           pop,
   output ipx_result_type head,
   output logic           head_valid,
   output logic           space
);

   ipx_result_type entry_ff [RSP_QUEUE_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_BITS:0]   count_ff, count_in;
   logic [RSP_PTR_BITS-1:0] wr_next;
   logic                    do_pop;

   always_comb begin
      head       = entry_ff[rd_ptr_ff];
      head_valid = count_ff != '0;
      // Room for two results regardless of what leaves this cycle.
      space      = count_ff <= (RSP_PTR_BITS + 1)'(RSP_QUEUE_DEPTH - 2);
      do_pop     = pop && head_valid;
      wr_next    = wr_ptr_ff + 1'b1;

      wr_ptr_in = wr_ptr_ff;
      if (push.first_valid && push.second_valid) begin
         wr_ptr_in = wr_ptr_ff + (RSP_PTR_BITS)'(2);
      end else if (push.first_valid) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (RSP_PTR_BITS + 1)'(push.first_valid)
                           + (RSP_PTR_BITS + 1)'(push.second_valid)
                           - (RSP_PTR_BITS + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

/* rtl/ipv4_tcp_payload_extract_filter_core.sv */
// Top level of the IPv4/TCP payload extraction and filtering block.
//
//   Channel  Direction  Moves
//   req_     in         one captured frame byte with frame end and wire length
//   rsp_     out        a payload byte or an end-of-frame summary
//   csr_     in         write of one server address byte
//
// One frame byte is taken every cycle while the result queue has room; each request
// passes through an input register, the parser logic and into a four-entry result
// queue. A final byte that is also payload yields two results; the queue's free
// space, checked for two entries, sets req_tready.
// Reset is synchronous and clears frame state, counters and queue; the server
// address returns to its reset value. A stalled rsp_ side fills the queue and
// then holds the input register.
module ipv4_tcp_payload_extract_filter_core
   import ipx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // frame_byte [7:0], wire_length [23:8]
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // payload_byte, toward_server, from_server, is_tcp,
                                    // malformed, payload_length (17), client_next_seq,
                                    // server_next_seq, zero fill
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_end_ff;
   logic [15:0] s1_wire_ff;
   logic        s1_fire;
   ipx_ip_type  server_ip_ff;
   ipx_push_type   push;
   ipx_result_type head;
   logic           head_valid;
   logic           space;

   assign csr_ready   = 1'b1;
   assign s1_fire     = s1_valid_ff && space;
   assign req_tready  = !s1_valid_ff || s1_fire;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         server_ip_ff[0] <= SERVER_IP_RESET0;
         server_ip_ff[1] <= SERVER_IP_RESET1;
         server_ip_ff[2] <= SERVER_IP_RESET2;
         server_ip_ff[3] <= SERVER_IP_RESET3;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SERVER_IP0: server_ip_ff[0] <= csr_data;
               CSR_SERVER_IP1: server_ip_ff[1] <= csr_data;
               CSR_SERVER_IP2: server_ip_ff[2] <= csr_data;
               CSR_SERVER_IP3: server_ip_ff[3] <= csr_data;
               default: ;
            endcase
         end
      end
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata[7:0];
         s1_wire_ff <= req_tdata[23:8];
         s1_end_ff  <= req_tlast;
      end
   end

   ipx_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (s1_fire),
      .frame_byte  (s1_byte_ff),
      .frame_end   (s1_end_ff),
      .wire_length (s1_wire_ff),
      .server_ip   (server_ip_ff),
      .push        (push)
   );

   ipx_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tready),
      .head       (head),
      .head_valid (head_valid),
      .space      (space)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {3'b000, head.server_next_seq, head.client_next_seq,
                        head.payload_length, head.malformed, head.is_tcp,
                        head.from_server, head.toward_server, head.payload_byte};

   // A request is only processed when the queue can take both of its results.
   a_fire_has_room: assert property (@(posedge clock) disable iff (reset)
      push.first_valid |-> space)
      else $error("result pushed without queue room");

   // Only a summary closes a run, and every summary does.
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsp_tlast))
      else $error("summary and run end disagree");

   // A payload result never reports a malformed frame.
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[11] == 1'b0))
      else $error("payload result flagged malformed");

   // The input side only stalls while a held request waits for queue room.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && !space))
      else $error("input stalled without cause");

endmodule
